>>> design/gdr_pkg.sv
package gdr_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAM_DIV,
      ST_RAY_MUL,
      ST_RAY_SUM,
      ST_RCP_X,
      ST_RCP_Y,
      ST_SIDE_MUL,
      ST_STEP,
      ST_READ,
      ST_CHECK,
      ST_PERP,
      ST_LH_DIV,
      ST_FRAC_MUL,
      ST_FINISH,
      ST_OUT
   } gdr_state_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic [2:0] REG_POS_X   = 3'd0;
   localparam logic [2:0] REG_POS_Y   = 3'd1;
   localparam logic [2:0] REG_DIR_X   = 3'd2;
   localparam logic [2:0] REG_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_PLANE_X = 3'd4;
   localparam logic [2:0] REG_PLANE_Y = 3'd5;
   localparam logic [2:0] REG_SCR_W   = 3'd6;
   localparam logic [2:0] REG_SCR_H   = 3'd7;

   // shared divider control
   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [32:0] den;
   } gdr_div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quo;
   } gdr_div_rsp_type;

endpackage

>>> design/gdr_divider.sv
module gdr_divider
   import gdr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  gdr_div_req_type div_req,
   output gdr_div_rsp_type div_rsp
);

   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (div_req.start) begin
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[47]} - {1'b0, den_ff};
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

>>> design/gdr_map_ram.sv
module gdr_map_ram
   import gdr_pkg::*;
#(
   parameter int AddrBits = 12
)(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [7:0]          wr_data,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [7:0]          rd_data
);

   logic [7:0] mem [2**AddrBits];

   // write one cell, read one cell, registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> design/grid_dda_wall_raycaster.sv
// Casts one screen column against a grid map of 8-bit wall codes held in a
// synchronous RAM with one read port. A map write request (opcode 0) keeps the
// block idle, so writes can follow back to back. A cast request (opcode 1)
// runs four passes of a shared bit-serial divider (camera x, two reciprocals,
// line height), and each DDA step passes through a step state, a map read
// state and a check state. A divider pass is skipped when its ray component
// or the distance is zero, and the step that leaves the map skips its check.
// A finished cast waits while an earlier result is still held on the output.
// A cast whose column is not below screen_width is accepted but gives no
// result. After reset the block sweeps every map cell to zero before it takes
// its first request; configuration writes are taken throughout.
module grid_dda_wall_raycaster
   import gdr_pkg::*;
#(
   parameter int MAP_WIDTH    = 64,
   parameter int MAP_HEIGHT   = 64,
   parameter int TEX_SIZE     = 64,
   parameter int NUM_TEXTURES = 8
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [9:0]         req_column,
   input  logic [5:0]         req_cell_x,
   input  logic [5:0]         req_cell_y,
   input  logic [7:0]         req_cell_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_wall_distance,
   output logic               rsp_hit_side,
   output logic signed [7:0]  rsp_hit_x,
   output logic signed [7:0]  rsp_hit_y,
   output logic [7:0]         rsp_wall_value,
   output logic [7:0]         rsp_texture_index,
   output logic [7:0]         rsp_texture_column,
   output logic [15:0]        rsp_line_height,
   output logic [9:0]         rsp_draw_start,
   output logic [9:0]         rsp_draw_end,
   output logic               rsp_out_of_map,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [21:0]        csr_write_data
);

   localparam int XBITS  = $clog2(MAP_WIDTH);
   localparam int YBITS  = $clog2(MAP_HEIGHT);
   localparam int ABITS  = $clog2(MAP_WIDTH * MAP_HEIGHT);
   localparam int CELLS  = MAP_WIDTH * MAP_HEIGHT;
   localparam int LIMIT  = 2 * (MAP_WIDTH + MAP_HEIGHT) + 4;
   localparam int LBITS  = $clog2(LIMIT + 1);
   localparam int TBITS  = $clog2(TEX_SIZE);
   localparam logic [10:0] TEX_MAX  = 11'(TEX_SIZE - 1);
   localparam logic [7:0]  TIDX_MAX = 8'(NUM_TEXTURES - 1);

   // configuration registers
   logic [21:0] pos_x_ff, pos_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [10:0] scr_w_ff, scr_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 22'd98304;
         pos_y_ff   <= 22'd98304;
         dir_x_ff   <= -16'sd16384;
         dir_y_ff   <= 16'sd0;
         plane_x_ff <= 16'sd0;
         plane_y_ff <= 16'sd10813;
         scr_w_ff   <= 11'd640;
         scr_h_ff   <= 11'd480;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_POS_X:   pos_x_ff   <= csr_write_data;
            REG_POS_Y:   pos_y_ff   <= csr_write_data;
            REG_DIR_X:   dir_x_ff   <= csr_write_data[15:0];
            REG_DIR_Y:   dir_y_ff   <= csr_write_data[15:0];
            REG_PLANE_X: plane_x_ff <= csr_write_data[15:0];
            REG_PLANE_Y: plane_y_ff <= csr_write_data[15:0];
            REG_SCR_W:   scr_w_ff   <= csr_write_data[10:0];
            REG_SCR_H:   scr_h_ff   <= csr_write_data[10:0];
            default:     ;
         endcase
      end
   end

   gdr_state_type state_ff, state_in;

   // datapath registers
   logic signed [17:0]  cam_ff, cam_in;
   logic signed [34:0]  mx_prod_ff, mx_prod_in, my_prod_ff, my_prod_in;
   logic signed [19:0]  ray_x_ff, ray_x_in, ray_y_ff, ray_y_in;
   logic [32:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic [49:0]         sx_ff, sx_in, sy_ff, sy_in;
   logic signed [9:0]   mx_ff, mx_in, my_ff, my_in;
   logic                side_ff, side_in;
   logic                oom_ff, oom_in;
   logic [LBITS-1:0]    iter_ff, iter_in;
   logic [31:0]         perp_ff, perp_in;
   logic [15:0]         lh_ff, lh_in;
   logic signed [53:0]  fprod_ff, fprod_in;
   logic [7:0]          wall_ff, wall_in;
   logic [ABITS:0]      clr_ff, clr_in;
   logic                clr_done_ff, clr_done_in;

   // output register
   logic        ov_ff, ov_in;
   logic [31:0] o_dist_ff, o_dist_in;
   logic        o_side_ff, o_side_in;
   logic [7:0]  o_hx_ff, o_hx_in, o_hy_ff, o_hy_in;
   logic [7:0]  o_wall_ff, o_wall_in, o_tidx_ff, o_tidx_in, o_tcol_ff, o_tcol_in;
   logic [15:0] o_lh_ff, o_lh_in;
   logic [9:0]  o_ds_ff, o_ds_in, o_de_ff, o_de_in;
   logic        o_oom_ff, o_oom_in;

   gdr_div_req_type div_req;
   gdr_div_rsp_type div_rsp;

   gdr_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic             ram_we;
   logic [ABITS-1:0] ram_waddr, ram_raddr;
   logic [7:0]       ram_wdata, ram_rdata;

   gdr_map_ram #(.AddrBits(ABITS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // request acceptance
   logic acc;
   logic in_map_wr;
   assign req_ready = (state_ff == ST_IDLE) && clr_done_ff;
   assign acc       = req_valid && req_ready;
   assign in_map_wr = ({26'd0, req_cell_x} < 32'(MAP_WIDTH))
                      && ({26'd0, req_cell_y} < 32'(MAP_HEIGHT));

   // map RAM ports: clear sweep, cell writes, walk reads
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ABITS'(({26'd0, req_cell_y} * 32'(MAP_WIDTH)) + {26'd0, req_cell_x});
      ram_wdata = req_cell_value;
      if (!clr_done_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff[ABITS-1:0];
         ram_wdata = 8'd0;
      end else if (acc && req_opcode == OP_WRITE && in_map_wr) begin
         ram_we = 1'b1;
      end
      ram_raddr = ABITS'(32'(my_ff[YBITS-1:0]) * 32'(MAP_WIDTH)
                         + 32'(mx_ff[XBITS-1:0]));
   end

   // next-state logic
   logic step_x;
   logic mx_out, my_out;
   assign step_x = sx_ff < sy_ff;
   assign mx_out = (mx_ff < 10'sd0) || (mx_ff >= 10'(MAP_WIDTH));
   assign my_out = (my_ff < 10'sd0) || (my_ff >= 10'(MAP_HEIGHT));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (acc && req_opcode == OP_CAST
                      && {1'b0, req_column} < scr_w_ff) state_in = ST_CAM_DIV;
         ST_CAM_DIV:  if (div_rsp.done) state_in = ST_RAY_MUL;
         ST_RAY_MUL:  state_in = ST_RAY_SUM;
         ST_RAY_SUM:  state_in = ST_RCP_X;
         ST_RCP_X:    if (div_rsp.done || ray_x_ff == 20'sd0) state_in = ST_RCP_Y;
         ST_RCP_Y:    if (div_rsp.done || ray_y_ff == 20'sd0) state_in = ST_SIDE_MUL;
         ST_SIDE_MUL: state_in = ST_STEP;
         ST_STEP:     state_in = ST_READ;
         ST_READ:     state_in = (mx_out || my_out) ? ST_PERP : ST_CHECK;
         ST_CHECK: begin
            if (ram_rdata != 8'd0 || iter_ff == LBITS'(LIMIT)) state_in = ST_PERP;
            else state_in = ST_STEP;
         end
         ST_PERP:     state_in = ST_LH_DIV;
         ST_LH_DIV:   if (div_rsp.done || perp_ff == 32'd0) state_in = ST_FRAC_MUL;
         ST_FRAC_MUL: state_in = ST_FINISH;
         ST_FINISH:   if (!ov_ff) state_in = ST_OUT;
         ST_OUT:      if (!ov_ff) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // divider launches
   logic [19:0] abs_ry;
   assign abs_ry = ray_y_ff[19] ? 20'(-ray_y_ff) : 20'(ray_y_ff);

   always_comb begin
      div_req = '0;
      if (state_ff == ST_IDLE && state_in == ST_CAM_DIV) begin
         div_req.start = 1'b1;
         div_req.num   = {21'd0, req_column, 17'd0};
         div_req.den   = {22'd0, scr_w_ff};
      end else if (state_ff == ST_RAY_SUM && ray_x_in != 20'sd0) begin
         div_req.start = 1'b1;
         div_req.num   = 48'd1 << 30;
         div_req.den   = 33'(ray_x_in[19] ? 20'(-ray_x_in) : 20'(ray_x_in));
      end else if (state_ff == ST_RCP_X && state_in == ST_RCP_Y && ray_y_ff != 20'sd0) begin
         div_req.start = 1'b1;
         div_req.num   = 48'd1 << 30;
         div_req.den   = {13'd0, abs_ry};
      end else if (state_ff == ST_PERP && perp_in != 32'd0) begin
         div_req.start = 1'b1;
         div_req.num   = {21'd0, scr_h_ff, 16'd0};
         div_req.den   = {1'b0, perp_in};
      end
   end

   // datapath
   logic [16:0] fx, fy;
   logic [16:0] fxm, fym;
   logic [49:0] perp_wide;
   logic [15:0] frac;
   logic [21:0] frac_sum;
   logic [TBITS+15:0] tprod;
   logic [10:0] tcol;
   logic [15:0] lh_half;
   logic [10:0] hh;
   logic signed [17:0] ds_s, de_s;
   logic [8:0]  tmp9;

   assign fx  = {1'b0, pos_x_ff[15:0]};
   assign fy  = {1'b0, pos_y_ff[15:0]};
   assign fxm = ray_x_ff[19] ? fx : 17'd65536 - fx;
   assign fym = ray_y_ff[19] ? fy : 17'd65536 - fy;
   assign perp_wide = side_ff ? sy_ff - {17'd0, dy_ff} : sx_ff - {17'd0, dx_ff};

   always_comb begin
      cam_in     = cam_ff;
      mx_prod_in = mx_prod_ff;
      my_prod_in = my_prod_ff;
      ray_x_in   = ray_x_ff;
      ray_y_in   = ray_y_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      mx_in      = mx_ff;
      my_in      = my_ff;
      side_in    = side_ff;
      oom_in     = oom_ff;
      iter_in    = iter_ff;
      perp_in    = perp_ff;
      lh_in      = lh_ff;
      fprod_in   = fprod_ff;
      wall_in    = wall_ff;
      tprod      = '0;
      tcol       = '0;
      frac_sum   = '0;
      frac       = '0;
      lh_half    = '0;
      hh         = '0;
      ds_s       = '0;
      de_s       = '0;
      tmp9       = '0;
      ov_in      = ov_ff;
      o_dist_in  = o_dist_ff;
      o_side_in  = o_side_ff;
      o_hx_in    = o_hx_ff;
      o_hy_in    = o_hy_ff;
      o_wall_in  = o_wall_ff;
      o_tidx_in  = o_tidx_ff;
      o_tcol_in  = o_tcol_ff;
      o_lh_in    = o_lh_ff;
      o_ds_in    = o_ds_ff;
      o_de_in    = o_de_ff;
      o_oom_in   = o_oom_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (state_ff)
         ST_CAM_DIV: if (div_rsp.done) cam_in = 18'(div_rsp.quo) - 18'sd65536;
         ST_RAY_MUL: begin
            mx_prod_in = 35'(plane_x_ff * cam_ff);
            my_prod_in = 35'(plane_y_ff * cam_ff);
         end
         ST_RAY_SUM: begin
            ray_x_in = 20'(dir_x_ff) + 20'(mx_prod_ff >>> 16);
            ray_y_in = 20'(dir_y_ff) + 20'(my_prod_ff >>> 16);
         end
         ST_RCP_X: begin
            if (ray_x_ff == 20'sd0) dx_in = 33'hFFFFFFFF;
            else if (div_rsp.done) dx_in = div_rsp.quo[32:0];
         end
         ST_RCP_Y: begin
            if (ray_y_ff == 20'sd0) dy_in = 33'hFFFFFFFF;
            else if (div_rsp.done) dy_in = div_rsp.quo[32:0];
         end
         ST_SIDE_MUL: begin
            sx_in   = 50'((fxm * dx_ff) >> 16);
            sy_in   = 50'((fym * dy_ff) >> 16);
            mx_in   = 10'(pos_x_ff[21:16]);
            my_in   = 10'(pos_y_ff[21:16]);
            iter_in = '0;
            oom_in  = 1'b0;
         end
         ST_STEP: begin
            if (step_x) begin
               sx_in   = sx_ff + {17'd0, dx_ff};
               mx_in   = ray_x_ff[19] ? mx_ff - 10'sd1 : mx_ff + 10'sd1;
               side_in = 1'b0;
            end else begin
               sy_in   = sy_ff + {17'd0, dy_ff};
               my_in   = ray_y_ff[19] ? my_ff - 10'sd1 : my_ff + 10'sd1;
               side_in = 1'b1;
            end
            iter_in = iter_ff + 1'b1;
         end
         ST_READ: if (mx_out || my_out) begin
            oom_in  = 1'b1;
            wall_in = 8'd0;
         end
         ST_CHECK: wall_in = ram_rdata;
         ST_PERP: perp_in = (perp_wide[49:32] != 18'd0) ? 32'hFFFFFFFF : perp_wide[31:0];
         ST_LH_DIV: begin
            if (perp_ff == 32'd0) lh_in = 16'hFFFF;
            else if (div_rsp.done)
               lh_in = (div_rsp.quo[47:16] != 32'd0) ? 16'hFFFF : div_rsp.quo[15:0];
         end
         ST_FRAC_MUL: begin
            fprod_in = side_ff ? 54'($signed({1'b0, perp_ff}) * ray_x_ff)
                               : 54'($signed({1'b0, perp_ff}) * ray_y_ff);
         end
         ST_FINISH: begin
            frac_sum = (side_ff ? pos_x_ff : pos_y_ff) + 22'(fprod_ff >>> 14);
            frac     = frac_sum[15:0];
            tprod    = (TBITS+16)'(frac) * (TBITS+16)'(TEX_SIZE);
            tcol     = 11'(tprod >> 16);
            if ((!side_ff && !ray_x_ff[19] && ray_x_ff != 20'sd0)
                || (side_ff && ray_y_ff[19]))
               tcol = TEX_MAX - tcol;
            lh_half = lh_ff >> 1;
            hh      = scr_h_ff >> 1;
            ds_s    = 18'(hh) - 18'(lh_half);
            if (ds_s < 18'sd0) ds_s = '0;
            de_s    = 18'(lh_half) + 18'(hh);
            if (de_s >= 18'(scr_h_ff)) de_s = 18'(scr_h_ff) - 18'sd1;
            if (de_s < 18'sd0) de_s = '0;
            if (ds_s > 18'sd1023) ds_s = 18'sd1023;
            if (de_s > 18'sd1023) de_s = 18'sd1023;
            tmp9 = (wall_ff == 8'd0) ? 9'd0 : 9'(wall_ff) - 9'd1;
            // hold the output register while an earlier result waits
            if (!ov_ff) begin
               o_dist_in = perp_ff;
               o_side_in = side_ff;
               o_hx_in   = mx_ff[7:0];
               o_hy_in   = my_ff[7:0];
               o_wall_in = wall_ff;
               o_tidx_in = (tmp9[7:0] > TIDX_MAX) ? TIDX_MAX : tmp9[7:0];
               o_tcol_in = tcol[7:0];
               o_lh_in   = lh_ff;
               o_ds_in   = ds_s[9:0];
               o_de_in   = de_s[9:0];
               o_oom_in  = oom_ff;
            end
         end
         ST_OUT: if (!ov_ff) ov_in = 1'b1;
         default: ;
      endcase
   end

   // clear sweep after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == (ABITS+1)'(CELLS - 1)) clr_done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cam_ff     <= cam_in;
      mx_prod_ff <= mx_prod_in;
      my_prod_ff <= my_prod_in;
      ray_x_ff   <= ray_x_in;
      ray_y_ff   <= ray_y_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      side_ff    <= side_in;
      oom_ff     <= oom_in;
      iter_ff    <= iter_in;
      perp_ff    <= perp_in;
      lh_ff      <= lh_in;
      fprod_ff   <= fprod_in;
      wall_ff    <= wall_in;
      o_dist_ff  <= o_dist_in;
      o_side_ff  <= o_side_in;
      o_hx_ff    <= o_hx_in;
      o_hy_ff    <= o_hy_in;
      o_wall_ff  <= o_wall_in;
      o_tidx_ff  <= o_tidx_in;
      o_tcol_ff  <= o_tcol_in;
      o_lh_ff    <= o_lh_in;
      o_ds_ff    <= o_ds_in;
      o_de_ff    <= o_de_in;
      o_oom_ff   <= o_oom_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         ov_ff       <= 1'b0;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ov_ff       <= ov_in;
         clr_ff      <= clr_in;
         clr_done_ff <= clr_done_in;
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_wall_distance  = o_dist_ff;
   assign rsp_hit_side       = o_side_ff;
   assign rsp_hit_x          = o_hx_ff;
   assign rsp_hit_y          = o_hy_ff;
   assign rsp_wall_value     = o_wall_ff;
   assign rsp_texture_index  = o_tidx_ff;
   assign rsp_texture_column = o_tcol_ff;
   assign rsp_line_height    = o_lh_ff;
   assign rsp_draw_start     = o_ds_ff;
   assign rsp_draw_end       = o_de_ff;
   assign rsp_out_of_map     = o_oom_ff;

endmodule
